/* rtl/quadrature_and_limit_switch_hub_macros.svh */
// ----------------------------------------------------------------------------
// Quadrature hub assertion macros
// Clocked assertion helpers used by the hub checker.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_AND_LIMIT_SWITCH_HUB_MACROS_SVH
`define QUADRATURE_AND_LIMIT_SWITCH_HUB_MACROS_SVH

// Check a property on every rising clk edge, off while reset is low.
`define QLSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but the property is evaluated during reset as well.
`define QLSH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/qlsh_pkg.sv */
// ----------------------------------------------------------------------------
// qlsh_pkg
// Shared types, command codes and constants for the quadrature hub.
// ----------------------------------------------------------------------------
`default_nettype none

package qlsh_pkg;

  localparam int NUM_AXES    = 3;
  localparam int AXIS_FIRST  = 0;
  localparam int AXIS_SECOND = 1;
  localparam int AXIS_FOCUS  = 2;
  localparam int AXIS_W      = 2;
  localparam int COUNT_W     = 32;
  localparam int SWITCH_W    = 10;
  localparam int PORT_W      = 8;

  localparam logic [31:0] QUAD_TABLE_RESET = 32'h3443_C11C;

  // Port B bit positions
  localparam int SW9_BIT    = 6;
  localparam int SW10_BIT   = 7;
  localparam int FOCUS_BIT0 = 2;
  localparam int FOCUS_BIT1 = 3;
  localparam logic [PORT_W-1:0] FOCUS_MASK = 8'h0C;

  // Switch bitmap positions fed by port B
  localparam int SW9_IDX  = 8;
  localparam int SW10_IDX = 9;

  typedef enum logic [2:0] {
    CMD_AXIS0  = 3'd0,
    CMD_AXIS1  = 3'd1,
    CMD_PORT_B = 3'd2,
    CMD_PORT_K = 3'd3,
    CMD_TICKS  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]                command;
    logic                      pin_a;
    logic                      pin_b;
    logic [PORT_W-1:0]         port_value;
    logic [AXIS_W-1:0]         axis;
    logic signed [COUNT_W-1:0] new_ticks;
  } item_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] first_count;
    logic signed [COUNT_W-1:0] second_count;
    logic signed [COUNT_W-1:0] focus_count;
    logic [SWITCH_W-1:0]       switches;
  } res_t;

  // Signed step from the 16-entry table, selected by {prev, new}.
  function automatic logic signed [COUNT_W-1:0] quad_delta(
    input logic [31:0] table_bits,
    input logic [1:0]  prev_state,
    input logic [1:0]  new_state
  );
    logic [3:0] sel;
    logic [1:0] code;
    sel  = {prev_state, new_state};
    code = table_bits[{sel, 1'b0} +: 2];
    return {{(COUNT_W-2){code[1]}}, code};
  endfunction

endpackage

`default_nettype wire

/* rtl/quadrature_and_limit_switch_hub.sv */
// ----------------------------------------------------------------------------
// quadrature_and_limit_switch_hub
// Path: input register -> update -> result register; out_valid rises once
// an accepted item has moved on into the result register.
// Throughput: 1 item per cycle while out_stall is low.
// Reset (sync, rst_n low): counts 0, axis states 3, no switch pressed,
// port snapshots 0xFF, step table back to standard x4 decoding.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_and_limit_switch_hub
  import qlsh_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  // step table write
  input  wire logic                cfg_wr_en,
  input  wire logic [31:0]         cfg_wr_data,

  // item input
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_command,
  input  wire logic                in_pin_a,
  input  wire logic                in_pin_b,
  input  wire logic [PORT_W-1:0]   in_port_value,
  input  wire logic [AXIS_W-1:0]   in_axis,
  input  wire logic signed [COUNT_W-1:0] in_new_ticks,

  // result output
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [COUNT_W-1:0] out_first_axis_count,
  output logic signed [COUNT_W-1:0] out_second_axis_count,
  output logic signed [COUNT_W-1:0] out_focus_axis_count,
  output logic [SWITCH_W-1:0]      out_switch_states
);

  logic [31:0] step_table_r;

  // input register
  logic  in_v_r;
  item_t in_item_r;

  // result register
  logic  out_v_r;
  res_t  res_r;
  res_t  res_nxt;

  // The held item moves into the result register when that register is
  // empty or being drained this cycle. State updates on the same edge.
  logic adv;

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;

  // Step table; written only while the hub is idle: a user rule, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_table_r <= QUAD_TABLE_RESET;
    end else if (cfg_wr_en) begin
      step_table_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r.command    <= in_command;
      in_item_r.pin_a      <= in_pin_a;
      in_item_r.pin_b      <= in_pin_b;
      in_item_r.port_value <= in_port_value;
      in_item_r.axis       <= in_axis;
      in_item_r.new_ticks  <= in_new_ticks;
    end
  end

  // Counters, bitmap and snapshots; res_nxt is the state after the held item.
  qlsh_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .step_table (step_table_r),
    .item       (in_item_r),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_v_r;
  assign out_first_axis_count  = res_r.first_count;
  assign out_second_axis_count = res_r.second_count;
  assign out_focus_axis_count  = res_r.focus_count;
  assign out_switch_states     = res_r.switches;

endmodule

`default_nettype wire

/* rtl/qlsh_core.sv */
// ----------------------------------------------------------------------------
// qlsh_core
// Axis counters, switch bitmap and port snapshots with their update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module qlsh_core
  import qlsh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic [31:0] step_table,
  input  wire item_t       item,
  output res_t             res
);

  logic signed [COUNT_W-1:0] ticks_r   [NUM_AXES];
  logic signed [COUNT_W-1:0] ticks_nxt [NUM_AXES];
  logic [1:0]                prev_r    [NUM_AXES];
  logic [1:0]                prev_nxt  [NUM_AXES];
  logic [SWITCH_W-1:0]       sw_r, sw_nxt;
  logic [PORT_W-1:0]         last_b_r, last_b_nxt;
  logic [PORT_W-1:0]         last_k_r, last_k_nxt;

  logic [1:0]        pin_state;
  logic [1:0]        focus_state;
  logic [PORT_W-1:0] changed_b;
  logic [PORT_W-1:0] changed_k;

  assign pin_state   = {item.pin_a, item.pin_b};
  assign focus_state = {item.port_value[FOCUS_BIT1], item.port_value[FOCUS_BIT0]};
  assign changed_b   = item.port_value ^ last_b_r;
  assign changed_k   = item.port_value ^ last_k_r;

  always_comb begin
    ticks_nxt  = ticks_r;
    prev_nxt   = prev_r;
    sw_nxt     = sw_r;
    last_b_nxt = last_b_r;
    last_k_nxt = last_k_r;
    case (cmd_t'(item.command))
      CMD_AXIS0: begin
        ticks_nxt[AXIS_FIRST] = ticks_r[AXIS_FIRST]
                              + quad_delta(step_table, prev_r[AXIS_FIRST], pin_state);
        prev_nxt[AXIS_FIRST]  = pin_state;
      end
      CMD_AXIS1: begin
        ticks_nxt[AXIS_SECOND] = ticks_r[AXIS_SECOND]
                               + quad_delta(step_table, prev_r[AXIS_SECOND], pin_state);
        prev_nxt[AXIS_SECOND]  = pin_state;
      end
      CMD_PORT_B: begin
        last_b_nxt = item.port_value;
        if (changed_b[SW9_BIT]) begin
          sw_nxt[SW9_IDX] = ~item.port_value[SW9_BIT];
        end
        if (changed_b[SW10_BIT]) begin
          sw_nxt[SW10_IDX] = ~item.port_value[SW10_BIT];
        end
        if (|(changed_b & FOCUS_MASK)) begin
          ticks_nxt[AXIS_FOCUS] = ticks_r[AXIS_FOCUS]
                                + quad_delta(step_table, prev_r[AXIS_FOCUS], focus_state);
          prev_nxt[AXIS_FOCUS]  = focus_state;
        end
      end
      CMD_PORT_K: begin
        // pressed = pin low, only for bits that moved
        last_k_nxt          = item.port_value;
        sw_nxt[PORT_W-1:0]  = (sw_r[PORT_W-1:0] & ~changed_k)
                            | (~item.port_value & changed_k);
      end
      CMD_TICKS: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (item.axis == AXIS_W'(i)) begin
            ticks_nxt[i] = item.new_ticks;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        ticks_r[i] <= '0;
        prev_r[i]  <= 2'b11;
      end
      sw_r     <= '0;
      last_b_r <= '1;
      last_k_r <= '1;
    end else if (en) begin
      ticks_r  <= ticks_nxt;
      prev_r   <= prev_nxt;
      sw_r     <= sw_nxt;
      last_b_r <= last_b_nxt;
      last_k_r <= last_k_nxt;
    end
  end

  assign res.first_count  = ticks_nxt[AXIS_FIRST];
  assign res.second_count = ticks_nxt[AXIS_SECOND];
  assign res.focus_count  = ticks_nxt[AXIS_FOCUS];
  assign res.switches     = sw_nxt;

endmodule

`default_nettype wire

/* rtl/qlsh_checker.sv */
// ----------------------------------------------------------------------------
// qlsh_checker
// Port-level checks for the quadrature hub, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadrature_and_limit_switch_hub_macros.svh"

module qlsh_checker
  import qlsh_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic signed [COUNT_W-1:0]  out_first_axis_count,
  input wire logic [SWITCH_W-1:0]        out_switch_states
);

  // A held result stays up.
  `QLSH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // A held result does not change.
  `QLSH_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_first_axis_count) && $stable(out_switch_states), "stalled result changed")

  // Input is only pushed back when a result is waiting and blocked.
  `QLSH_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with free result slot")

  // Every accepted item is followed by out_valid once it has passed the input and result registers.
  `QLSH_ASSERT(a_latency, in_valid && !in_stall |-> ##2 out_valid, "accepted item produced no result")

  // Nothing is offered right out of reset.
  `QLSH_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !out_valid && !in_stall, "busy after reset")

endmodule

bind quadrature_and_limit_switch_hub qlsh_checker u_qlsh_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_first_axis_count (out_first_axis_count),
  .out_switch_states    (out_switch_states)
);

`default_nettype wire

/* bench/hub_count_checker.sv */
// ----------------------------------------------------------------------------
// hub_count_checker
// Tracks the hub's counters and switch bitmap from the accepted items and
// compares every accepted result against the predicted one, field by field.
// ----------------------------------------------------------------------------
module hub_count_checker
  import qlsh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [2:0]                in_command,
  input  logic                      in_pin_a,
  input  logic                      in_pin_b,
  input  logic [PORT_W-1:0]         in_port_value,
  input  logic [AXIS_W-1:0]         in_axis,
  input  logic signed [COUNT_W-1:0] in_new_ticks,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [COUNT_W-1:0] out_first_axis_count,
  input  logic signed [COUNT_W-1:0] out_second_axis_count,
  input  logic signed [COUNT_W-1:0] out_focus_axis_count,
  input  logic [SWITCH_W-1:0]       out_switch_states,
  output int                        mismatches,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]         step_table;
  logic [COUNT_W-1:0]  ticks_now [NUM_AXES];
  logic [1:0]          quad_now [NUM_AXES];
  logic [SWITCH_W-1:0] pressed_now;
  logic [PORT_W-1:0]   port_b_seen;
  logic [PORT_W-1:0]   port_k_seen;
  res_t                counts_due [$];
  res_t                want_res;
  int                  fail_tally = 0;

  // sign-extended table entry for the {previous, new} state pair
  function automatic logic [COUNT_W-1:0] table_step(input logic [31:0] tbl,
                                                    input logic [1:0] prev_st,
                                                    input logic [1:0] next_st);
    logic [3:0] sel;
    logic [1:0] code;
    sel  = {prev_st, next_st};
    code = tbl[2*sel +: 2];
    return {{(COUNT_W-2){code[1]}}, code};
  endfunction

  task automatic advance_axis(input int idx, input logic [1:0] next_st);
    ticks_now[idx] = ticks_now[idx] + table_step(step_table, quad_now[idx], next_st);
    quad_now[idx]  = next_st;
  endtask

  task automatic apply_item(output res_t r);
    logic [PORT_W-1:0] changed;
    changed = '0;
    case (in_command)
      CMD_AXIS0: advance_axis(AXIS_FIRST, {in_pin_a, in_pin_b});
      CMD_AXIS1: advance_axis(AXIS_SECOND, {in_pin_a, in_pin_b});
      CMD_PORT_B: begin
        changed     = in_port_value ^ port_b_seen;
        port_b_seen = in_port_value;
        if (changed[SW9_BIT])  pressed_now[SW9_IDX]  = ~in_port_value[SW9_BIT];
        if (changed[SW10_BIT]) pressed_now[SW10_IDX] = ~in_port_value[SW10_BIT];
        if ((changed & FOCUS_MASK) != '0)
          advance_axis(AXIS_FOCUS, {in_port_value[FOCUS_BIT1], in_port_value[FOCUS_BIT0]});
      end
      CMD_PORT_K: begin
        changed     = in_port_value ^ port_k_seen;
        port_k_seen = in_port_value;
        for (int k = 0; k < PORT_W; k++)
          if (changed[k]) pressed_now[k] = ~in_port_value[k];
      end
      CMD_TICKS: begin
        if (in_axis < NUM_AXES) ticks_now[in_axis] = in_new_ticks;
      end
      default: ;  // status read
    endcase
    r.first_count  = ticks_now[AXIS_FIRST];
    r.second_count = ticks_now[AXIS_SECOND];
    r.focus_count  = ticks_now[AXIS_FOCUS];
    r.switches     = pressed_now;
  endtask

  task automatic check_field(input string fname, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", fname, want_v, got_v);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_table  = QUAD_TABLE_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        ticks_now[i] = '0;
        quad_now[i]  = 2'd3;
      end
      pressed_now = '0;
      port_b_seen = 8'hFF;
      port_k_seen = 8'hFF;
      counts_due.delete();
    end else begin
      if (cfg_wr_en) step_table = cfg_wr_data;
      // predict before comparing, in case a result leaves in the same cycle
      if (in_valid && !in_stall) begin
        apply_item(want_res);
        counts_due.push_back(want_res);
      end
      if (out_valid && !out_stall) begin
        if (counts_due.size() == 0) begin
          $error("result with no item outstanding");
          fail_tally++;
        end else begin
          want_res = counts_due.pop_front();
          check_field("first_axis_count", want_res.first_count, out_first_axis_count);
          check_field("second_axis_count", want_res.second_count, out_second_axis_count);
          check_field("focus_axis_count", want_res.focus_count, out_focus_axis_count);
          check_field("switch_states", {22'b0, want_res.switches},
                      {22'b0, out_switch_states});
        end
      end
    end
    mismatches <= fail_tally;
    pending    <= counts_due.size();
  end

endmodule

/* bench/tb_quadrature_and_limit_switch_hub.sv */
// ----------------------------------------------------------------------------
// tb_quadrature_and_limit_switch_hub
// Drives encoder samples, port bytes, tick loads and status reads into the
// hub under several step tables, with random idle and stall bursts; the
// checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_quadrature_and_limit_switch_hub
  import qlsh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]        CMD_STATUS_FIRST = 3'd5;  // 5..7 only report
  localparam logic [AXIS_W-1:0] AXIS_UNUSED      = 2'd3;  // tick load ignored
  localparam int                NUM_PHASES       = 7;
  localparam int                PHASE_ITEMS      = 100;
  localparam int                WATCHDOG_LIMIT   = 1000;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [31:0]               cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [2:0]                in_command;
  logic                      in_pin_a;
  logic                      in_pin_b;
  logic [PORT_W-1:0]         in_port_value;
  logic [AXIS_W-1:0]         in_axis;
  logic signed [COUNT_W-1:0] in_new_ticks;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COUNT_W-1:0] out_first_axis_count;
  logic signed [COUNT_W-1:0] out_second_axis_count;
  logic signed [COUNT_W-1:0] out_focus_axis_count;
  logic [SWITCH_W-1:0]       out_switch_states;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  int items_sent  = 0;
  bit tail_quiet  = 1'b0;  // last phase: no idle, no stall

  // What was last sent, so random motion follows legal Gray-code steps.
  // Focus axis state lives in port_b_last[3:2].
  logic [1:0]        enc_state [2];
  bit   [2:0]        spin_back;
  logic [PORT_W-1:0] port_b_last;
  logic [PORT_W-1:0] port_k_last;
  logic [31:0]       step_patterns [NUM_PHASES];

  // Gray sequence 0 -> 1 -> 3 -> 2 -> 0, indexed by current state
  logic [1:0] gray_fwd [0:3] = '{2'd1, 2'd3, 2'd0, 2'd2};
  logic [1:0] gray_bwd [0:3] = '{2'd2, 2'd0, 2'd3, 2'd1};

  quadrature_and_limit_switch_hub dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_pin_a              (in_pin_a),
    .in_pin_b              (in_pin_b),
    .in_port_value         (in_port_value),
    .in_axis               (in_axis),
    .in_new_ticks          (in_new_ticks),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_first_axis_count  (out_first_axis_count),
    .out_second_axis_count (out_second_axis_count),
    .out_focus_axis_count  (out_focus_axis_count),
    .out_switch_states     (out_switch_states)
  );

  hub_count_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_pin_a              (in_pin_a),
    .in_pin_b              (in_pin_b),
    .in_port_value         (in_port_value),
    .in_axis               (in_axis),
    .in_new_ticks          (in_new_ticks),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_first_axis_count  (out_first_axis_count),
    .out_second_axis_count (out_second_axis_count),
    .out_focus_axis_count  (out_focus_axis_count),
    .out_switch_states     (out_switch_states),
    .mismatches            (mismatches),
    .pending               (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: any stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quadrature_and_limit_switch_hub test failed");
      $finish;
    end
  end

  // Result-side back-pressure: random stalled bursts between open stretches.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!tail_quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic item_t pack_item(input logic [2:0] cmd, input logic pa,
                                      input logic pb, input logic [7:0] port,
                                      input logic [1:0] ax, input logic [31:0] ticks);
    item_t it;
    it.command    = cmd;
    it.pin_a      = pa;
    it.pin_b      = pb;
    it.port_value = port;
    it.axis       = ax;
    it.new_ticks  = ticks;
    return it;
  endfunction

  // Mostly legal motion with random content; some raw jumps, fully random
  // items and extreme tick loads as noise. Unused fields carry junk.
  function automatic item_t make_random_item();
    item_t      it;
    int         pick;
    int         k;
    logic [1:0] s;
    it = pack_item(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                   8'($urandom), 2'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // one legal step on axis 0 or 1, direction mostly held
      k = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) spin_back[k] = ~spin_back[k];
      s = spin_back[k] ? gray_bwd[enc_state[k]] : gray_fwd[enc_state[k]];
      it.command = (k == 0) ? CMD_AXIS0 : CMD_AXIS1;
      {it.pin_a, it.pin_b} = s;
    end else if (pick < 38) begin
      // raw pin pair: repeats and two-bit jumps included
      it.command = ($urandom_range(0, 1) == 0) ? CMD_AXIS0 : CMD_AXIS1;
    end else if (pick < 56) begin
      it.command = CMD_PORT_B;
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) == 0) spin_back[AXIS_FOCUS] = ~spin_back[AXIS_FOCUS];
        s = spin_back[AXIS_FOCUS] ? gray_bwd[port_b_last[3:2]] : gray_fwd[port_b_last[3:2]];
        it.port_value = port_b_last;
        // sometimes leave the focus pins alone so only switches move
        if ($urandom_range(0, 3) != 0) it.port_value[3:2] = s;
        if ($urandom_range(0, 2) == 0) it.port_value[7:6] = 2'($urandom);
        if ($urandom_range(0, 3) == 0) it.port_value ^= 8'h33 & 8'($urandom);
      end
    end else if (pick < 73) begin
      it.command = CMD_PORT_K;
      if ($urandom_range(0, 1) == 0)
        it.port_value = port_k_last ^ (8'h01 << $urandom_range(0, 7));
    end else if (pick < 83) begin
      it.command = CMD_TICKS;
      case ($urandom_range(0, 5))
        0: it.new_ticks = 32'h7FFF_FFFF;
        1: it.new_ticks = 32'h8000_0000;
        2: it.new_ticks = 32'hFFFF_FFFF;
        3: it.new_ticks = 32'h0000_0000;
        default: ;
      endcase
    end else if (pick < 90) begin
      it.command = CMD_STATUS_FIRST + 3'($urandom_range(0, 2));
    end
    return it;
  endfunction

  // Present one item and hold it until taken; then maybe idle for a burst.
  task automatic send_item(input item_t it);
    in_valid      <= 1'b1;
    in_command    <= it.command;
    in_pin_a      <= it.pin_a;
    in_pin_b      <= it.pin_b;
    in_port_value <= it.port_value;
    in_axis       <= it.axis;
    in_new_ticks  <= it.new_ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (it.command)
      CMD_AXIS0:  enc_state[0] = {it.pin_a, it.pin_b};
      CMD_AXIS1:  enc_state[1] = {it.pin_a, it.pin_b};
      CMD_PORT_B: port_b_last  = it.port_value;
      CMD_PORT_K: port_k_last  = it.port_value;
      default: ;
    endcase
    // idle bursts come in windows, so there are also gap-free stretches
    if (!tail_quiet && ((items_sent / 50) % 3 != 0) && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_command    <= '0;
    in_pin_a      <= 1'b0;
    in_pin_b      <= 1'b0;
    in_port_value <= '0;
    in_axis       <= '0;
    in_new_ticks  <= '0;
    enc_state[0]  = 2'd3;
    enc_state[1]  = 2'd3;
    spin_back     = '0;
    port_b_last   = 8'hFF;
    port_k_last   = 8'hFF;

    // tables: standard, all zero, all -1, random, all +1, all -2, standard
    step_patterns[0] = QUAD_TABLE_RESET;
    step_patterns[1] = 32'h0000_0000;
    step_patterns[2] = 32'hFFFF_FFFF;
    step_patterns[3] = $urandom;
    step_patterns[4] = 32'h5555_5555;
    step_patterns[5] = 32'hAAAA_AAAA;
    step_patterns[6] = QUAD_TABLE_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, on the reset-value table.
    // Axis 0: full forward turn, one step back, then a repeated state.
    send_item(pack_item(CMD_AXIS0, 1'b1, 1'b0, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_AXIS0, 1'b0, 1'b0, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_AXIS0, 1'b0, 1'b1, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_AXIS0, 1'b1, 1'b1, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_AXIS0, 1'b0, 1'b1, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_AXIS0, 1'b0, 1'b1, 8'h00, 2'd0, 32'd0));
    // axis 1: jump across both pins at once
    send_item(pack_item(CMD_AXIS1, 1'b0, 1'b0, 8'hFF, 2'd3, 32'hFFFF_FFFF));
    // counter loads at the positive and negative extremes, each followed by a step inward
    send_item(pack_item(CMD_TICKS, 1'b0, 1'b0, 8'h00, AXIS_W'(AXIS_FIRST), 32'h7FFF_FFFF));
    send_item(pack_item(CMD_AXIS0, 1'b1, 1'b1, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_TICKS, 1'b1, 1'b1, 8'hFF, AXIS_W'(AXIS_SECOND), 32'h8000_0000));
    send_item(pack_item(CMD_AXIS1, 1'b1, 1'b0, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_TICKS, 1'b0, 1'b0, 8'h00, AXIS_W'(AXIS_FOCUS), 32'hFFFF_FFFF));
    // tick load to axis value three changes nothing
    send_item(pack_item(CMD_TICKS, 1'b1, 1'b1, 8'hFF, AXIS_UNUSED, 32'h1234_5678));
    // port B: press 9/10 with a focus jump, focus step, change on bits 4 and 5 only,
    // then release everything
    send_item(pack_item(CMD_PORT_B, 1'b1, 1'b1, 8'h00, 2'd3, 32'hFFFF_FFFF));
    send_item(pack_item(CMD_PORT_B, 1'b0, 1'b0, 8'h04, 2'd0, 32'd0));
    send_item(pack_item(CMD_PORT_B, 1'b0, 1'b0, 8'h34, 2'd0, 32'd0));
    send_item(pack_item(CMD_PORT_B, 1'b0, 1'b0, 8'hFF, 2'd0, 32'd0));
    // port K: all pressed, mixed, unchanged byte, all released
    send_item(pack_item(CMD_PORT_K, 1'b0, 1'b0, 8'h00, 2'd0, 32'd0));
    send_item(pack_item(CMD_PORT_K, 1'b1, 1'b1, 8'hA5, 2'd3, 32'hFFFF_FFFF));
    send_item(pack_item(CMD_PORT_K, 1'b0, 1'b0, 8'hA5, 2'd0, 32'd0));
    send_item(pack_item(CMD_PORT_K, 1'b0, 1'b0, 8'hFF, 2'd0, 32'd0));
    // status reads with junk in every other field
    send_item(pack_item(CMD_STATUS_FIRST, 1'b1, 1'b1, 8'h5A, 2'd2, 32'hDEAD_BEEF));
    send_item(pack_item(CMD_STATUS_FIRST + 3'd1, 1'b0, 1'b1, 8'h00, 2'd0, 32'h8000_0000));
    send_item(pack_item(CMD_STATUS_FIRST + 3'd2, 1'b1, 1'b0, 8'hFF, 2'd1, 32'h7FFF_FFFF));

    // Random phases, one step table each; the table only changes while the
    // hub is empty. The last phase runs without idle or stall.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      tail_quiet = (p == NUM_PHASES - 1);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= step_patterns[p];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      repeat (PHASE_ITEMS) send_item(make_random_item());
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("quadrature_and_limit_switch_hub test passed");
    end else begin
      $display("quadrature_and_limit_switch_hub test failed");
    end
    $finish;
  end

endmodule
